>>> src/pidc_pkg.sv
// Shared types, widths and saturation helpers for the clamped PID controller.
`default_nettype none

package pidc_pkg;

    // Field and register widths
    localparam int DATA_W     = 32;
    localparam int STEP_W     = 31;
    localparam int ERR_W      = 33;
    localparam int DIFF_W     = 34;
    localparam int SUM_W      = 48;
    localparam int ISUM_X_W   = 66;
    localparam int DERIV_W    = 64;
    localparam int TERM_W     = 62;
    localparam int OSUM_W     = 64;
    localparam int CLAMP_W    = 2;
    localparam int OUT_TDATA_W = 40;

    // Serial multiplier geometry
    localparam int MCAND_W    = 64;
    localparam int MPLR_W     = 32;
    localparam int PROD_W     = 96;
    localparam int DIGIT_W    = 4;
    localparam int NUM_DIGITS = MPLR_W / DIGIT_W;

    // APB geometry
    localparam int APB_W      = 32;
    localparam int ADDR_W     = 5;

    // Register reset values
    localparam logic [STEP_W-1:0] STEP_TIME_RST = 31'd655;
    localparam logic [STEP_W-1:0] STEP_RATE_RST = 31'd6553600;
    localparam logic [DATA_W-1:0] OUT_MAX_RST   = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] OUT_MIN_RST   = 32'h8000_0000;

    typedef enum logic [2:0] {
        REG_GAIN_P    = 3'd0,
        REG_GAIN_I    = 3'd1,
        REG_GAIN_D    = 3'd2,
        REG_TARGET    = 3'd3,
        REG_STEP_TIME = 3'd4,
        REG_STEP_RATE = 3'd5,
        REG_OUT_MAX   = 3'd6,
        REG_OUT_MIN   = 3'd7
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_RUN,
        ST_CLAMP
    } state_t;

    typedef enum logic [2:0] {
        OP_INTEG,
        OP_DERIV,
        OP_PTERM,
        OP_ITERM,
        OP_DTERM
    } op_t;

    typedef enum logic [CLAMP_W-1:0] {
        CLAMP_NONE = 2'd0,
        CLAMP_HIGH = 2'd1,
        CLAMP_LOW  = 2'd2
    } clamp_t;

    typedef struct packed {
        logic                       start;
        logic signed [MCAND_W-1:0]  mcand;
        logic signed [MPLR_W-1:0]   mplr;
    } mul_req_t;

    typedef struct packed {
        logic                       done;
        logic        [PROD_W-1:0]   product;
    } mul_rsp_t;

    // Saturate the widened integral sum to the 48-bit state range
    function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [ISUM_X_W-1:0] v);
        logic signed [SUM_W-1:0] r;
        if ((&v[ISUM_X_W-1:SUM_W-1]) || (~|v[ISUM_X_W-1:SUM_W-1]))
            r = v[SUM_W-1:0];
        else if (v[ISUM_X_W-1])
            r = {1'b1, {(SUM_W-1){1'b0}}};
        else
            r = {1'b0, {(SUM_W-1){1'b1}}};
        return r;
    endfunction

    // Saturate a shifted product to the output term range
    function automatic logic signed [TERM_W-1:0] sat_term(input logic signed [PROD_W-1:0] v);
        logic signed [TERM_W-1:0] r;
        if ((&v[PROD_W-1:TERM_W-1]) || (~|v[PROD_W-1:TERM_W-1]))
            r = v[TERM_W-1:0];
        else if (v[PROD_W-1])
            r = {1'b1, {(TERM_W-1){1'b0}}};
        else
            r = {1'b0, {(TERM_W-1){1'b1}}};
        return r;
    endfunction

endpackage

`default_nettype wire

>>> src/pid_controller_clamped.sv
// Top level of the clamped PID controller: APB registers, sequencer and output register.
//
//  channel  | direction | handshake                   | payload
//  ---------+-----------+-----------------------------+---------------------------------------
//  s_axis   | in        | s_tvalid / s_tready         | s_tdata[31:0] sample
//  m_axis   | out       | m_tvalid / m_tready         | m_tdata[31:0] drive, [33:32] clamp_state
//  apb      | in        | psel, penable, pwrite, pready | paddr, pwdata, prdata
//
// A sample runs five products one after another on the shared 4-bit-digit multiplier, each
// a load in ST_START, then the digit steps and the writeback in ST_RUN, then a clamp state
// that loads the output register; only back in idle is s_tready high for the next sample.
// s_tready is high whenever the sequencer is idle, even while a result waits in the
// output register; the clamp cycle holds until that register is free.
// Reset (rst_n, async, active low) clears the integral and the previous error, and sets all
// configuration registers to their reset values.
`default_nettype none

module pid_controller_clamped
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    // APB configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pidc_pkg::ADDR_W-1:0]   paddr,
    input  logic [pidc_pkg::APB_W-1:0]    pwdata,
    output logic [pidc_pkg::APB_W-1:0]    prdata,
    output logic                          pready,
    // Input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [pidc_pkg::DATA_W-1:0]   s_tdata,   // [31:0] sample
    // Output stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [pidc_pkg::OUT_TDATA_W-1:0] m_tdata // [31:0] drive, [33:32] clamp_state
);
    import pidc_pkg::*;

    // Configuration registers
    logic signed [DATA_W-1:0] gain_p_reg, gain_i_reg, gain_d_reg, target_reg;
    logic signed [DATA_W-1:0] out_max_reg, out_min_reg;
    logic        [STEP_W-1:0] step_time_reg, step_rate_reg;
    logic                     cfg_wr;
    reg_idx_t                 cfg_idx;

    // Sequencer and datapath
    state_t                    state_reg, state_next;
    op_t                       op_reg, op_next;
    logic signed [ERR_W-1:0]   err_reg, err_next;
    logic signed [ERR_W-1:0]   last_err_reg, last_err_next;
    logic signed [SUM_W-1:0]   isum_reg, isum_next;
    logic signed [DERIV_W-1:0] deriv_reg, deriv_next;
    logic signed [OSUM_W-1:0]  osum_reg, osum_next;
    logic                      out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0]    out_data_reg, out_data_next;

    logic                      in_xfer;
    logic                      mul_start;
    logic                      out_free;
    logic                      out_load;
    logic signed [DIFF_W-1:0]  diff;
    logic signed [PROD_W-1:0]  shifted;
    logic signed [ISUM_X_W-1:0] isum_wide;
    logic signed [TERM_W-1:0]  term;
    logic signed [OSUM_W-1:0]  lim_max, lim_min, clamped;
    clamp_t                    clamp_st;
    mul_req_t                  mul_req;
    mul_rsp_t                  mul_rsp;

    // APB decode
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg    <= '0;
            gain_i_reg    <= '0;
            gain_d_reg    <= '0;
            target_reg    <= '0;
            step_time_reg <= STEP_TIME_RST;
            step_rate_reg <= STEP_RATE_RST;
            out_max_reg   <= OUT_MAX_RST;
            out_min_reg   <= OUT_MIN_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_GAIN_P:    gain_p_reg    <= pwdata[DATA_W-1:0];
                REG_GAIN_I:    gain_i_reg    <= pwdata[DATA_W-1:0];
                REG_GAIN_D:    gain_d_reg    <= pwdata[DATA_W-1:0];
                REG_TARGET:    target_reg    <= pwdata[DATA_W-1:0];
                REG_STEP_TIME: step_time_reg <= pwdata[STEP_W-1:0];
                REG_STEP_RATE: step_rate_reg <= pwdata[STEP_W-1:0];
                REG_OUT_MAX:   out_max_reg   <= pwdata[DATA_W-1:0];
                REG_OUT_MIN:   out_min_reg   <= pwdata[DATA_W-1:0];
            endcase
        end
    end

    // Register readback
    always_comb
    begin
        unique case (cfg_idx)
            REG_GAIN_P:    prdata = gain_p_reg;
            REG_GAIN_I:    prdata = gain_i_reg;
            REG_GAIN_D:    prdata = gain_d_reg;
            REG_TARGET:    prdata = target_reg;
            REG_STEP_TIME: prdata = {1'b0, step_time_reg};
            REG_STEP_RATE: prdata = {1'b0, step_rate_reg};
            REG_OUT_MAX:   prdata = out_max_reg;
            REG_OUT_MIN:   prdata = out_min_reg;
        endcase
    end

    // Shared serial multiplier
    pidc_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    // Select operands for the current product
    assign diff = DIFF_W'(err_reg) - DIFF_W'(last_err_reg);

    always_comb
    begin
        mul_req.start = mul_start;
        unique case (op_reg)
            OP_INTEG:
            begin
                mul_req.mcand = MCAND_W'(err_reg);
                mul_req.mplr  = MPLR_W'({1'b0, step_time_reg});
            end
            OP_DERIV:
            begin
                mul_req.mcand = MCAND_W'(diff);
                mul_req.mplr  = MPLR_W'({1'b0, step_rate_reg});
            end
            OP_PTERM:
            begin
                mul_req.mcand = MCAND_W'(err_reg);
                mul_req.mplr  = gain_p_reg;
            end
            OP_ITERM:
            begin
                mul_req.mcand = MCAND_W'(isum_reg);
                mul_req.mplr  = gain_i_reg;
            end
            OP_DTERM:
            begin
                mul_req.mcand = deriv_reg;
                mul_req.mplr  = gain_d_reg;
            end
            default:
            begin
                mul_req.mcand = '0;
                mul_req.mplr  = '0;
            end
        endcase
    end

    // Scale the finished product and form the running sums
    always_comb
    begin
        shifted   = $signed(mul_rsp.product) >>> FRAC_BITS;
        isum_wide = ISUM_X_W'(isum_reg) + ISUM_X_W'(shifted);
        term      = sat_term(shifted);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (s_tvalid)
                    state_next = ST_START;
            ST_START:
                state_next = ST_RUN;
            ST_RUN:
                if (mul_rsp.done)
                    state_next = (op_reg == OP_DTERM) ? ST_CLAMP : ST_START;
            ST_CLAMP:
                if (out_free)
                    state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        s_tready  = 1'b0;
        mul_start = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE:  s_tready  = 1'b1;
            ST_START: mul_start = 1'b1;
            ST_RUN:   ;
            ST_CLAMP: out_load  = out_free;
        endcase
    end

    assign in_xfer = s_tvalid && s_tready;

    // Datapath updates: load the error on a transfer, retire each product
    always_comb
    begin
        op_next       = op_reg;
        err_next      = err_reg;
        last_err_next = last_err_reg;
        isum_next     = isum_reg;
        deriv_next    = deriv_reg;
        osum_next     = osum_reg;
        if (in_xfer)
        begin
            err_next  = ERR_W'(target_reg) - ERR_W'($signed(s_tdata));
            osum_next = '0;
            op_next   = OP_INTEG;
        end
        else if ((state_reg == ST_RUN) && mul_rsp.done)
        begin
            unique case (op_reg)
                OP_INTEG:
                begin
                    isum_next = sat_sum(isum_wide);
                    op_next   = OP_DERIV;
                end
                OP_DERIV:
                begin
                    deriv_next    = shifted[DERIV_W-1:0];
                    last_err_next = err_reg;
                    op_next       = OP_PTERM;
                end
                OP_PTERM:
                begin
                    osum_next = osum_reg + OSUM_W'(term);
                    op_next   = OP_ITERM;
                end
                OP_ITERM:
                begin
                    osum_next = osum_reg + OSUM_W'(term);
                    op_next   = OP_DTERM;
                end
                OP_DTERM:
                    osum_next = osum_reg + OSUM_W'(term);
                default:
                    op_next = OP_INTEG;
            endcase
        end
    end

    // Clamp to the upper limit first, then the lower one
    always_comb
    begin
        lim_max  = OSUM_W'(out_max_reg);
        lim_min  = OSUM_W'(out_min_reg);
        clamped  = osum_reg;
        clamp_st = CLAMP_NONE;
        if (clamped > lim_max)
        begin
            clamped  = lim_max;
            clamp_st = CLAMP_HIGH;
        end
        if (clamped < lim_min)
        begin
            clamped  = lim_min;
            clamp_st = CLAMP_LOW;
        end
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {{(OUT_TDATA_W - DATA_W - CLAMP_W){1'b0}},
                              clamp_st, clamped[DATA_W-1:0]};
        end
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    // Control and loop state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_INTEG;
            out_valid_reg <= 1'b0;
            isum_reg      <= '0;
            last_err_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            out_valid_reg <= out_valid_next;
            isum_reg      <= isum_next;
            last_err_reg  <= last_err_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        err_reg      <= err_next;
        deriv_reg    <= deriv_next;
        osum_reg     <= osum_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

>>> src/pidc_mul.sv
// Digit-serial signed multiplier: 64-bit multiplicand, 32-bit multiplier, 4 bits per cycle.
`default_nettype none

module pidc_mul
(
    input  logic               clk,
    input  logic               rst_n,
    input  pidc_pkg::mul_req_t req,
    output pidc_pkg::mul_rsp_t rsp
);
    import pidc_pkg::*;

    localparam int ACC_W  = MCAND_W + DIGIT_W + 1;
    localparam int CNT_W  = $clog2(NUM_DIGITS);
    localparam int FULL_W = ACC_W + MPLR_W;

    logic signed [MCAND_W-1:0] mcand_reg, mcand_next;
    logic        [MPLR_W-1:0]  mplr_reg, mplr_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic        [MPLR_W-1:0]  lo_reg, lo_next;
    logic        [CNT_W-1:0]   cnt_reg, cnt_next;
    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;

    logic                      last_digit;
    logic signed [DIGIT_W:0]   digit;
    logic signed [ACC_W-1:0]   partial;
    logic signed [ACC_W-1:0]   step_sum;
    logic        [FULL_W-1:0]  full;

    // Pick the current digit; the top digit carries the multiplier sign
    always_comb
    begin
        last_digit = (cnt_reg == CNT_W'(NUM_DIGITS - 1));
        if (last_digit)
            digit = $signed({mplr_reg[DIGIT_W-1], mplr_reg[DIGIT_W-1:0]});
        else
            digit = $signed({1'b0, mplr_reg[DIGIT_W-1:0]});
        partial  = ACC_W'(mcand_reg) * ACC_W'(digit);
        step_sum = acc_reg + partial;
    end

    // Load on start, otherwise add one partial product and shift a digit out
    always_comb
    begin
        mcand_next = mcand_reg;
        mplr_next  = mplr_reg;
        acc_next   = acc_reg;
        lo_next    = lo_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (req.start)
        begin
            mcand_next = req.mcand;
            mplr_next  = req.mplr;
            acc_next   = '0;
            cnt_next   = '0;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next  = step_sum >>> DIGIT_W;
            lo_next   = {step_sum[DIGIT_W-1:0], lo_reg[MPLR_W-1:DIGIT_W]};
            mplr_next = mplr_reg >> DIGIT_W;
            cnt_next  = cnt_reg + 1'b1;
            if (last_digit)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Operand and accumulator registers
    always_ff @(posedge clk)
    begin
        mcand_reg <= mcand_next;
        mplr_reg  <= mplr_next;
        acc_reg   <= acc_next;
        lo_reg    <= lo_next;
    end

    // Product is the accumulator over the shifted-out low digits
    assign full        = {acc_reg, lo_reg};
    assign rsp.done    = done_reg;
    assign rsp.product = full[PROD_W-1:0];

endmodule

`default_nettype wire
